@@ hdl/scu_pkg.sv @@
`timescale 1ns / 1ps

package scu_pkg;

    // block length limit and sample format
    localparam int MAX_LEN_DEF = 4096;
    localparam int SAMPLE_W    = 16;

    // accumulator widths
    localparam int WSUM_W = 64;
    localparam int PSUM_W = 48;
    localparam int V_W    = 33;   // weight value: sample or sample squared

    // centroid format
    localparam int CEN_W   = 32;
    localparam int FRAC_W  = 16;
    localparam int QUO_W   = 31;  // quotient bits produced by the divider

    // depth of the queue between accumulator and divider
    localparam int QUEUE_DEPTH = 2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    // finished block sums handed to the divider
    typedef struct packed {
        logic [WSUM_W-1:0] wsum;
        logic [PSUM_W-1:0] psum;
        logic              ovf;
    } block_sums_t;

endpackage

@@ hdl/scu_front.sv @@
`timescale 1ns / 1ps

module scu_front #(
    parameter int MAX_LEN = scu_pkg::MAX_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          push,
    output logic                          full,
    input  logic [scu_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          last_sample,
    output logic                          q_push,
    output scu_pkg::block_sums_t          q_data,
    input  logic                          q_full
);
    import scu_pkg::*;

    localparam int IDX_W  = $clog2(MAX_LEN + 1);
    localparam int PROD_W = IDX_W + 1 + V_W;

    logic                    energy_mode_reg;
    logic [IDX_W-1:0]        idx_reg;
    logic                    ovf_reg;

    logic                    s0_valid_reg, s0_mode_reg, s0_acc_reg, s0_last_reg, s0_ovf_reg;
    logic signed [SAMPLE_W-1:0] s0_x_reg;
    logic [IDX_W-1:0]        s0_n_reg;

    logic                    s1_valid_reg, s1_acc_reg, s1_last_reg, s1_ovf_reg;
    logic signed [V_W-1:0]   s1_v_reg;
    logic [IDX_W-1:0]        s1_n_reg;

    logic                    s2_valid_reg, s2_acc_reg, s2_last_reg, s2_ovf_reg;
    logic signed [V_W-1:0]   s2_v_reg;
    logic signed [PROD_W-1:0] s2_prod_reg;

    logic [WSUM_W-1:0]       wsum_reg;
    logic [PSUM_W-1:0]       psum_reg;

    logic                    adv, accept, at_limit;
    logic signed [31:0]      sq;
    logic signed [V_W-1:0]   v_next;
    logic signed [PROD_W-1:0] n_ext, v_ext, prod_next;
    logic [WSUM_W-1:0]       wsum_add;
    logic [PSUM_W-1:0]       psum_add;

    // hold the whole pipe while a finished block waits for queue space
    assign adv    = !(s2_valid_reg && s2_last_reg && q_full);
    assign full   = !adv;
    assign accept = push && adv;
    assign at_limit = (idx_reg == IDX_W'(MAX_LEN));

    // mode register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            energy_mode_reg <= 1'b0;
        else if (cfg_wr_en)
            energy_mode_reg <= cfg_wr_data;
    end

    // sample index and length overflow of the current block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ovf_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (last_sample)
            begin
                idx_reg <= '0;
                ovf_reg <= 1'b0;
            end
            else if (at_limit)
                ovf_reg <= 1'b1;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    // stage 1 value and stage 2 product
    assign sq     = 32'(s0_x_reg) * 32'(s0_x_reg);
    assign v_next = s0_mode_reg ? V_W'(sq) : V_W'(s0_x_reg);
    assign n_ext  = PROD_W'(signed'({1'b0, s1_n_reg}));
    assign v_ext  = PROD_W'(s1_v_reg);
    assign prod_next = n_ext * v_ext;

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s0_valid_reg <= accept;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s0_x_reg    <= signed'(sample);
            s0_n_reg    <= idx_reg;
            s0_mode_reg <= energy_mode_reg;
            s0_acc_reg  <= !at_limit;
            s0_last_reg <= last_sample;
            s0_ovf_reg  <= ovf_reg || at_limit;

            s1_v_reg    <= v_next;
            s1_n_reg    <= s0_n_reg;
            s1_acc_reg  <= s0_acc_reg;
            s1_last_reg <= s0_last_reg;
            s1_ovf_reg  <= s0_ovf_reg;

            s2_prod_reg <= prod_next;
            s2_v_reg    <= s1_v_reg;
            s2_acc_reg  <= s1_acc_reg;
            s2_last_reg <= s1_last_reg;
            s2_ovf_reg  <= s1_ovf_reg;
        end
    end

    // accumulate, hand the sums off at block end
    assign wsum_add = s2_acc_reg ? wsum_reg + WSUM_W'(s2_prod_reg) : wsum_reg;
    assign psum_add = s2_acc_reg ? psum_reg + PSUM_W'(s2_v_reg) : psum_reg;

    assign q_push      = adv && s2_valid_reg && s2_last_reg;
    assign q_data.wsum = wsum_add;
    assign q_data.psum = psum_add;
    assign q_data.ovf  = s2_ovf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsum_reg <= '0;
            psum_reg <= '0;
        end
        else if (adv && s2_valid_reg)
        begin
            if (s2_last_reg)
            begin
                wsum_reg <= '0;
                psum_reg <= '0;
            end
            else
            begin
                wsum_reg <= wsum_add;
                psum_reg <= psum_add;
            end
        end
    end

endmodule

@@ hdl/scu_queue.sv @@
`timescale 1ns / 1ps

module scu_queue #(
    parameter int DEPTH = scu_pkg::QUEUE_DEPTH
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr,
    input  scu_pkg::block_sums_t wr_data,
    output logic                 full,
    input  logic                 rd,
    output scu_pkg::block_sums_t rd_data,
    output logic                 empty
);
    import scu_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    block_sums_t        entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr && !full;
    assign do_rd   = rd && !empty;
    assign rd_data = entry_reg[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_wr)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

@@ hdl/scu_divider.sv @@
`timescale 1ns / 1ps

module scu_divider (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    input  scu_pkg::block_sums_t        q_data,
    output logic                        q_pop,
    output logic                        empty,
    input  logic                        pop,
    output logic [scu_pkg::CEN_W-1:0]   centroid,
    output logic [1:0]                  status
);
    import scu_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_ROUND = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    localparam int CNT_W = $clog2(QUO_W);

    logic [2:0]          state_reg, state_next;
    logic [WSUM_W-1:0]   an_reg;
    logic [PSUM_W-1:0]   ad_reg;
    logic                neg_reg;
    logic [1:0]          st_reg;
    logic [PSUM_W-1:0]   rem_reg;
    logic [QUO_W-1:0]    quo_reg;
    logic [QUO_W-1:0]    low_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic [CEN_W-1:0]    mag_reg;

    logic                out_valid_reg;
    logic [CEN_W-1:0]    centroid_reg;
    logic [1:0]          status_reg;

    logic                num_neg, den_neg, sat, ge, rnd, slot_free;
    logic [WSUM_W-1:0]   an_next;
    logic [PSUM_W-1:0]   ad_next;
    logic [1:0]          st_next;
    logic [PSUM_W:0]     trial, ad_ext;
    logic [CEN_W-1:0]    limit, mag_sum;

    assign num_neg = q_data.wsum[WSUM_W-1];
    assign den_neg = q_data.psum[PSUM_W-1];
    assign an_next = num_neg ? (~q_data.wsum + 1'b1) : q_data.wsum;
    assign ad_next = den_neg ? (~q_data.psum + 1'b1) : q_data.psum;
    assign st_next = q_data.ovf ? ST_TOO_LONG
                   : ((q_data.psum == '0) ? ST_ZERO_DEN : ST_OK);

    assign q_pop     = (state_reg == S_IDLE) && !q_empty;
    assign slot_free = !out_valid_reg || pop;

    // saturation test: integer quotient reaches 2^15
    assign sat   = an_reg >= {1'b0, ad_reg, 15'b0};
    assign limit = neg_reg ? {1'b1, {(CEN_W-1){1'b0}}} : {1'b0, {(CEN_W-1){1'b1}}};

    // one restoring step
    assign ad_ext = {1'b0, ad_reg};
    assign trial  = {rem_reg, low_reg[QUO_W-1]};
    assign ge     = trial >= ad_ext;

    // round half away from zero on the magnitude
    assign rnd     = {rem_reg, 1'b0} >= ad_ext;
    assign mag_sum = {1'b0, quo_reg} + CEN_W'(rnd);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (!q_empty)
                    state_next = (st_next == ST_OK) ? S_CHECK : S_DONE;
            S_CHECK:
                state_next = sat ? S_DONE : S_DIV;
            S_DIV:
                if (cnt_reg == CNT_W'(QUO_W - 1))
                    state_next = S_ROUND;
            S_ROUND:
                state_next = S_DONE;
            S_DONE:
                if (slot_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                an_reg  <= an_next;
                ad_reg  <= ad_next;
                neg_reg <= num_neg ^ den_neg;
                st_reg  <= st_next;
                mag_reg <= '0;
            end
            S_CHECK:
            begin
                mag_reg <= limit;
                rem_reg <= an_reg[WSUM_W-2:15];
                low_reg <= {an_reg[14:0], {FRAC_W{1'b0}}};
                quo_reg <= '0;
                cnt_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg <= ge ? PSUM_W'(trial - ad_ext) : trial[PSUM_W-1:0];
                quo_reg <= {quo_reg[QUO_W-2:0], ge};
                low_reg <= {low_reg[QUO_W-2:0], 1'b0};
                cnt_reg <= cnt_reg + 1'b1;
            end
            S_ROUND:
                mag_reg <= (mag_sum > limit) ? limit : mag_sum;
            default:
            begin
            end
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == S_DONE && slot_free)
            out_valid_reg <= 1'b1;
        else if (pop)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE && slot_free)
        begin
            centroid_reg <= neg_reg ? (~mag_reg + 1'b1) : mag_reg;
            status_reg   <= st_reg;
        end
    end

    assign empty    = !out_valid_reg;
    assign centroid = centroid_reg;
    assign status   = status_reg;

endmodule

@@ hdl/signal_centroid_unit.sv @@
`timescale 1ns / 1ps

// Temporal centroid of sample blocks: sum(n*v)/sum(v) with n counted from 0, v the sample or,
// with energy_mode set, its square. One sample is taken per cycle while full is low, through
// a three-stage multiply/accumulate pipe; the sample marked last_sample closes the block and
// yields one item: the centroid as signed Q16.16 (rounded, saturated) and a status (ok, zero
// denominator, block longer than MAX_LEN). Finished block sums go through a two-entry queue
// to a divider that retires one quotient bit per cycle; in the back end a block goes through
// load, saturation check, 31 divide steps, round and output, and one with an error status or
// a saturated quotient skips ahead to output. Blocks coming faster than the divider drains
// them back up the queue and full rises. energy_mode is sampled as each sample is accepted.
module signal_centroid_unit #(
    parameter int MAX_LEN = scu_pkg::MAX_LEN_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic                          cfg_wr_data,
    input  logic                          push,
    output logic                          full,
    input  logic [scu_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          last_sample,
    output logic                          empty,
    input  logic                          pop,
    output logic [scu_pkg::CEN_W-1:0]     centroid,
    output logic [1:0]                    status
);
    import scu_pkg::*;

    logic        q_wr, q_full, q_rd, q_empty;
    block_sums_t q_wr_data, q_rd_data;

    // accumulator front end
    scu_front #(
        .MAX_LEN(MAX_LEN)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .push(push),
        .full(full),
        .sample(sample),
        .last_sample(last_sample),
        .q_push(q_wr),
        .q_data(q_wr_data),
        .q_full(q_full)
    );

    // block sums waiting for the divider
    scu_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .wr(q_wr),
        .wr_data(q_wr_data),
        .full(q_full),
        .rd(q_rd),
        .rd_data(q_rd_data),
        .empty(q_empty)
    );

    // divider back end
    scu_divider u_divider (
        .clk(clk),
        .rst_n(rst_n),
        .q_empty(q_empty),
        .q_data(q_rd_data),
        .q_pop(q_rd),
        .empty(empty),
        .pop(pop),
        .centroid(centroid),
        .status(status)
    );

endmodule

@@ hdl/signal_centroid_unit_chk.sv @@
`timescale 1ns / 1ps

module signal_centroid_unit_chk (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         empty,
    input logic                         pop,
    input logic [scu_pkg::CEN_W-1:0]    centroid,
    input logic [1:0]                   status
);
    import scu_pkg::*;

    // nothing waits on the result side while in reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |-> empty)
        else $error("result shown during reset");

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && !pop |=> !empty && $stable(centroid) && $stable(status))
        else $error("waiting result changed");

    // only defined status codes
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (status == ST_OK || status == ST_ZERO_DEN || status == ST_TOO_LONG))
        else $error("undefined status code");

    // error results carry a zero centroid
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty && status != ST_OK |-> centroid == '0)
        else $error("error result with nonzero centroid");

endmodule

bind signal_centroid_unit signal_centroid_unit_chk u_chk (
    .clk(clk),
    .rst_n(rst_n),
    .empty(empty),
    .pop(pop),
    .centroid(centroid),
    .status(status)
);
